// ===== rtl/core/merge_sort_by_length_assert.svh =====
// assertion macros for the length sorter
// every macro expects clk_i and rst_ni in scope
`ifndef MERGE_SORT_BY_LENGTH_ASSERT_SVH
`define MERGE_SORT_BY_LENGTH_ASSERT_SVH

// consequent checked in the same cycle
`define MSBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MSBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/msbl_pkg.sv =====
package msbl_pkg;

  localparam int unsigned SIZE     = 32;
  localparam int unsigned KEY_BITS = 12;
  localparam int unsigned TAG_BITS = 6;
  localparam int unsigned ENT_W    = KEY_BITS + TAG_BITS;
  localparam int unsigned IDX_W    = $clog2(SIZE);
  localparam int unsigned CNT_W    = $clog2(SIZE + 1);
  // room for a run start plus two run widths
  localparam int unsigned SUM_W    = CNT_W + 2;

  typedef logic [ENT_W-1:0] entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_RD,
    ST_CMP,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/core/merge_sort_by_length.sv =====
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// request   | start_i / busy_o   | key_length_i, item_tag_i, last_item_i
// result    | valid_o (strobe)   | sorted_length_o, sorted_tag_o, final_result_o,
//           |                    | truncated_o
//
// a request is taken while idle; the one marked last starts the sort
// sort: ceil(log2 n) merge passes, each a setup then a read and compare per element;
//   every element needs a registered read of both run heads from the source memory
//   before its compare; results then stream out one per cycle; busy_o is high
//   from the last request until the final read is issued
// reset clears control only; memories hold no reset value
// the receiver cannot stall, so each result is shown for exactly one cycle
module merge_sort_by_length (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [msbl_pkg::KEY_BITS-1:0] key_length_i,
  input  logic [msbl_pkg::TAG_BITS-1:0] item_tag_i,
  input  logic                          last_item_i,
  output logic                          valid_o,
  output logic [msbl_pkg::KEY_BITS-1:0] sorted_length_o,
  output logic [msbl_pkg::TAG_BITS-1:0] sorted_tag_o,
  output logic                          final_result_o,
  output logic                          truncated_o
);

  import msbl_pkg::*;

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // items stored so far
  logic             ovf_q, ovf_d;       // a request was dropped in this batch
  logic [CNT_W-1:0] n_q, n_d;           // size of the batch being sorted
  logic             trunc_q, trunc_d;
  logic             src_q, src_d;       // memory holding the current runs
  logic [CNT_W:0]   w_q, w_d;           // run width of this pass

  // merge pointers: left run [i, iend), right run [j, jend), write slot k
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] iend_q, iend_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] jend_q, jend_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic             emit_q, emit_d;
  logic             emit_last_q, emit_last_d;

  // memory ports
  logic             we0, we1;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  entry_t           r0a, r0b, r1a, r1b;

  logic             accept;
  logic             room;
  entry_t           head_a, head_b, pick;
  logic             take_left;
  logic [CNT_W-1:0] k_next;
  logic             k_at_end;
  logic             seg_end;
  logic             pass_skip;
  logic [CNT_W-1:0] seg_base;
  logic [SUM_W-1:0] seg_s1, seg_s2, n_ext;
  logic [CNT_W-1:0] seg_mid, seg_hi;

  assign accept = start_i && (state_q == ST_IDLE);
  assign room   = count_q < CNT_W'(SIZE);

  // heads of both runs, straight from the registered read ports
  assign head_a = src_q ? r1a : r0a;
  assign head_b = src_q ? r1b : r0b;

  // equal keys take the right run first: ties leave in reverse arrival order
  assign take_left = (i_q < iend_q) &&
                     ((j_q >= jend_q) ||
                      (head_a[ENT_W-1:TAG_BITS] > head_b[ENT_W-1:TAG_BITS]));
  assign pick      = take_left ? head_a : head_b;

  assign k_next    = k_q + CNT_W'(1);
  assign k_at_end  = (k_next == n_q);
  assign seg_end   = (k_next == jend_q);
  assign pass_skip = (w_q >= {1'b0, n_q});

  // bounds of the next pair of runs, clipped to the batch size
  assign seg_base = (state_q == ST_PASS) ? '0 : jend_q;
  assign n_ext    = SUM_W'(n_q);
  assign seg_s1   = SUM_W'(seg_base) + SUM_W'(w_q);
  assign seg_s2   = seg_s1 + SUM_W'(w_q);
  assign seg_mid  = (seg_s1 < n_ext) ? seg_s1[CNT_W-1:0] : n_q;
  assign seg_hi   = (seg_s2 < n_ext) ? seg_s2[CNT_W-1:0] : n_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_item_i) state_d = ST_PASS;
      end
      ST_PASS: begin
        state_d = pass_skip ? ST_OUT : ST_RD;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = k_at_end ? ST_PASS : ST_RD;
      end
      ST_OUT: begin
        if (k_at_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    trunc_d     = trunc_q;
    src_d       = src_q;
    w_d         = w_q;
    i_d         = i_q;
    iend_d      = iend_q;
    j_d         = j_q;
    jend_d      = jend_q;
    k_d         = k_q;
    emit_d      = 1'b0;
    emit_last_d = emit_last_q;
    we0         = 1'b0;
    we1         = 1'b0;
    waddr       = count_q[IDX_W-1:0];
    wdata       = {key_length_i, item_tag_i};
    raddr_a     = i_q[IDX_W-1:0];
    raddr_b     = j_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // loading always fills memory 0
          if (room) begin
            we0     = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            n_d     = room ? count_q + CNT_W'(1) : count_q;
            trunc_d = ovf_q || !room;
            count_d = '0;
            ovf_d   = 1'b0;
            src_d   = 1'b0;
            w_d     = (CNT_W + 1)'(1);
          end
        end
      end
      ST_PASS: begin
        k_d = '0;
        if (!pass_skip) begin
          i_d    = '0;
          iend_d = seg_mid;
          j_d    = seg_mid;
          jend_d = seg_hi;
        end
      end
      ST_RD: begin
        // heads of both runs are being read
      end
      ST_CMP: begin
        waddr = k_q[IDX_W-1:0];
        wdata = pick;
        we0   = src_q;
        we1   = !src_q;
        if (take_left) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          j_d = j_q + CNT_W'(1);
        end
        k_d = k_next;
        if (k_at_end) begin
          src_d = !src_q;
          w_d   = w_q << 1;
        end else if (seg_end) begin
          i_d    = jend_q;
          iend_d = seg_mid;
          j_d    = seg_mid;
          jend_d = seg_hi;
        end
      end
      ST_OUT: begin
        // one read a cycle, data shows with the strobe in the next cycle
        raddr_a     = k_q[IDX_W-1:0];
        emit_d      = 1'b1;
        emit_last_d = k_at_end;
        k_d         = k_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      trunc_q     <= 1'b0;
      src_q       <= 1'b0;
      w_q         <= '0;
      i_q         <= '0;
      iend_q      <= '0;
      j_q         <= '0;
      jend_q      <= '0;
      k_q         <= '0;
      emit_q      <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      trunc_q     <= trunc_d;
      src_q       <= src_d;
      w_q         <= w_d;
      i_q         <= i_d;
      iend_q      <= iend_d;
      j_q         <= j_d;
      jend_q      <= jend_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      emit_last_q <= emit_last_d;
    end
  end

  // ping-pong run memories: one is read while the other is written
  msbl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SIZE)
  ) u_ram0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (r0a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (r0b)
  );

  msbl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SIZE)
  ) u_ram1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (r1a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (r1b)
  );

  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = emit_q;
  assign sorted_length_o = head_a[ENT_W-1:TAG_BITS];
  assign sorted_tag_o    = head_a[TAG_BITS-1:0];
  assign final_result_o  = emit_q && emit_last_q;
  assign truncated_o     = emit_q && trunc_q;

  `include "merge_sort_by_length_assert.svh"

  `MSBL_ASSERT_NOW(a_final_strobe, final_result_o, valid_o, "final flag without strobe")
  `MSBL_ASSERT_NOW(a_merge_head, state_q == ST_CMP, (i_q < iend_q) || (j_q < jend_q), "merge with both runs empty")
  `MSBL_ASSERT_NEXT(a_read_then_cmp, state_q == ST_RD, state_q == ST_CMP, "compare does not follow read")
  `MSBL_ASSERT_NOW(a_out_range, state_q == ST_OUT, k_q < n_q, "read beyond batch")

endmodule

// ===== rtl/core/msbl_ram.sv =====
module msbl_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;

  typedef logic [msbl_pkg::KEY_BITS-1:0] key_t;
  typedef logic [msbl_pkg::TAG_BITS-1:0] tag_t;

  // result record as seen on the output ports
  typedef struct packed {
    logic [msbl_pkg::KEY_BITS-1:0] len;
    logic [msbl_pkg::TAG_BITS-1:0] tag;
    logic                          fin;
    logic                          trunc;
  } sorted_rec_t;

  // one row of the directed table; a typed row carries its own answer
  typedef struct packed {
    logic [msbl_pkg::KEY_BITS-1:0] key;
    logic [msbl_pkg::TAG_BITS-1:0] tag;
    logic                          last;
    logic                          typed;
    sorted_rec_t                   want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS    = 23;
  localparam int unsigned RAND_ITEMS  = 350;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned KEY_MAX = (1 << msbl_pkg::KEY_BITS) - 1;
  localparam int unsigned TAG_MAX = (1 << msbl_pkg::TAG_BITS) - 1;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [msbl_pkg::KEY_BITS-1:0] key_length_i;
  logic [msbl_pkg::TAG_BITS-1:0] item_tag_i;
  logic                          last_item_i;
  logic                          valid_o;
  logic [msbl_pkg::KEY_BITS-1:0] sorted_length_o;
  logic [msbl_pkg::TAG_BITS-1:0] sorted_tag_o;
  logic                          final_result_o;
  logic                          truncated_o;

  merge_sort_by_length DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .key_length_i   (key_length_i),
    .item_tag_i     (item_tag_i),
    .last_item_i    (last_item_i),
    .valid_o        (valid_o),
    .sorted_length_o(sorted_length_o),
    .sorted_tag_o   (sorted_tag_o),
    .final_result_o (final_result_o),
    .truncated_o    (truncated_o)
  );

  // directed table: single-item batches with the answer typed in, then
  // batches of ties, extremes and ordered keys left to the predictor
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // single items at the extremes and in alternating bit patterns
    '{12'd4095, 6'd63, 1'b1, 1'b1, '{12'd4095, 6'd63, 1'b1, 1'b0}},
    '{12'd0,    6'd0,  1'b1, 1'b1, '{12'd0,    6'd0,  1'b1, 1'b0}},
    '{12'hAAA,  6'd42, 1'b1, 1'b1, '{12'hAAA,  6'd42, 1'b1, 1'b0}},
    // three equal keys, whose output order only the tie rule decides
    '{12'd100,  6'd1,  1'b0, 1'b0, '0},
    '{12'd100,  6'd2,  1'b0, 1'b0, '0},
    '{12'd100,  6'd3,  1'b0, 1'b0, '0},
    '{12'h555,  6'd21, 1'b0, 1'b0, '0},
    // mixed extremes with repeated keys
    '{12'd0,    6'd10, 1'b0, 1'b0, '0},
    '{12'd4095, 6'd11, 1'b0, 1'b0, '0},
    '{12'd7,    6'd12, 1'b0, 1'b0, '0},
    '{12'd4095, 6'd13, 1'b0, 1'b0, '0},
    '{12'd2048, 6'd14, 1'b0, 1'b0, '0},
    '{12'd7,    6'd15, 1'b1, 1'b0, '0},
    // ascending input, fully reversed on output
    '{12'd1,    6'd20, 1'b0, 1'b0, '0},
    '{12'd2,    6'd21, 1'b0, 1'b0, '0},
    '{12'd3,    6'd22, 1'b0, 1'b0, '0},
    '{12'd4,    6'd23, 1'b0, 1'b0, '0},
    '{12'd5,    6'd24, 1'b1, 1'b0, '0},
    // two-item and three-item ties
    '{12'd5,    6'd30, 1'b0, 1'b0, '0},
    '{12'd5,    6'd31, 1'b1, 1'b0, '0},
    '{12'd9,    6'd33, 1'b0, 1'b0, '0},
    '{12'd9,    6'd34, 1'b0, 1'b0, '0},
    '{12'd9,    6'd35, 1'b1, 1'b0, '0}
  };

  // predictor state: the batch as collected so far
  logic [msbl_pkg::KEY_BITS-1:0] batch_keys [msbl_pkg::SIZE];
  logic [msbl_pkg::TAG_BITS-1:0] batch_tags [msbl_pkg::SIZE];
  int unsigned                   batch_fill;
  bit                            batch_dropped;

  sorted_rec_t pending_results [$];   // sorted results still to come out
  sorted_rec_t batch_out [$];         // results produced by the last request
  int unsigned failures = 0;
  bit          idling_on;
  int unsigned stall_cycles;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // merge [lo, mid] with [mid+1, hi]; left wins only on a strictly larger key
  function automatic void merge_runs(int lo, int mid, int hi);
    logic [msbl_pkg::KEY_BITS-1:0] k_copy [msbl_pkg::SIZE];
    logic [msbl_pkg::TAG_BITS-1:0] t_copy [msbl_pkg::SIZE];
    int i;
    int j;
    int k;
    for (int n = lo; n <= hi; n++) begin
      k_copy[n] = batch_keys[n];
      t_copy[n] = batch_tags[n];
    end
    i = lo;
    j = mid + 1;
    for (k = lo; k <= hi; k++) begin
      if (j > hi || (i <= mid && k_copy[i] > k_copy[j])) begin
        batch_keys[k] = k_copy[i];
        batch_tags[k] = t_copy[i];
        i++;
      end else begin
        batch_keys[k] = k_copy[j];
        batch_tags[k] = t_copy[j];
        j++;
      end
    end
  endfunction

  // top-down merge sort, recursion unrolled onto an explicit stack so the
  // merges happen in the same post-order as the recursive form
  function automatic void sort_batch(int count);
    int lo_st [64];
    int hi_st [64];
    bit seen_st [64];
    int sp;
    int lo;
    int hi;
    int mid;
    if (count < 2) return;
    sp = 1;
    lo_st[0] = 0;
    hi_st[0] = count - 1;
    seen_st[0] = 1'b0;
    while (sp > 0) begin
      sp--;
      lo = lo_st[sp];
      hi = hi_st[sp];
      if (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (seen_st[sp]) begin
          merge_runs(lo, mid, hi);
        end else begin
          // revisit this range after both halves, left half first
          lo_st[sp] = lo;   hi_st[sp] = hi;  seen_st[sp] = 1'b1; sp++;
          lo_st[sp] = mid + 1; hi_st[sp] = hi; seen_st[sp] = 1'b0; sp++;
          lo_st[sp] = lo;   hi_st[sp] = mid; seen_st[sp] = 1'b0; sp++;
        end
      end
    end
  endfunction

  // take one accepted request into the batch; on the last one, fill batch_out
  function automatic void predict_sorted(logic [msbl_pkg::KEY_BITS-1:0] key,
                                         logic [msbl_pkg::TAG_BITS-1:0] tag,
                                         logic last);
    sorted_rec_t rec;
    batch_out.delete();
    if (batch_fill < msbl_pkg::SIZE) begin
      batch_keys[batch_fill] = key;
      batch_tags[batch_fill] = tag;
      batch_fill++;
    end else begin
      // batch full: request dropped, but a last mark still closes the batch
      batch_dropped = 1'b1;
    end
    if (!last) return;
    sort_batch(batch_fill);
    for (int k = 0; k < batch_fill; k++) begin
      rec.len   = batch_keys[k];
      rec.tag   = batch_tags[k];
      rec.fin   = (k + 1 == batch_fill);
      rec.trunc = batch_dropped;
      batch_out = {batch_out, rec};
    end
    batch_fill = 0;
    batch_dropped = 1'b0;
  endfunction

  // present one request and hold it until the block takes it
  task automatic send_request(logic [msbl_pkg::KEY_BITS-1:0] key,
                              logic [msbl_pkg::TAG_BITS-1:0] tag,
                              logic last);
    int unsigned gap;
    if (idling_on && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      // junk on the payload while start is low, the block must ignore it
      key_length_i <= key_t'($urandom_range(KEY_MAX));
      item_tag_i   <= tag_t'($urandom_range(TAG_MAX));
      last_item_i  <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    key_length_i <= key;
    item_tag_i   <= tag;
    last_item_i  <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // random key: often from a few values so that ties are common
  function automatic logic [msbl_pkg::KEY_BITS-1:0] pick_key();
    case ($urandom_range(7))
      0:       return '0;
      1:       return key_t'(KEY_MAX);
      2, 3:    return key_t'($urandom_range(3));
      default: return key_t'($urandom_range(KEY_MAX));
    endcase
  endfunction

  // result checker: the receiver never stalls, so every strobe is a result
  always @(posedge clk_i) begin
    sorted_rec_t want;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result len=%0d tag=%0d fin=%0b trunc=%0b", $time,
                 sorted_length_o, sorted_tag_o, final_result_o, truncated_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (sorted_length_o !== want.len) begin
          $display("%0t: sorted_length expected %0d actual %0d", $time, want.len,
                   sorted_length_o);
          failures++;
        end
        if (sorted_tag_o !== want.tag) begin
          $display("%0t: sorted_tag expected %0d actual %0d", $time, want.tag,
                   sorted_tag_o);
          failures++;
        end
        if (final_result_o !== want.fin) begin
          $display("%0t: final_result expected %0b actual %0b", $time, want.fin,
                   final_result_o);
          failures++;
        end
        if (truncated_o !== want.trunc) begin
          $display("%0t: truncated expected %0b actual %0b", $time, want.trunc,
                   truncated_o);
          failures++;
        end
      end
    end
  end

  // watchdog: too long with neither a request taken nor a result shown
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("merge_sort_by_length verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned batch_len;
    int unsigned batch_no;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    key_length_i  <= '0;
    item_tag_i    <= '0;
    last_item_i   <= 1'b0;
    batch_fill    = 0;
    batch_dropped = 1'b0;
    idling_on     = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].key, dir_rows[r].tag, dir_rows[r].last);
      predict_sorted(dir_rows[r].key, dir_rows[r].tag, dir_rows[r].last);
      if (dir_rows[r].typed) begin
        pending_results = {pending_results, dir_rows[r].want};
      end else begin
        pending_results = {pending_results, batch_out};
      end
    end

    // random batches: mostly short, now and then full or overflowing,
    // the first two forced to one past full and exactly full
    sent = 0;
    batch_no = 0;
    while (sent < RAND_ITEMS) begin
      if (batch_no == 0) begin
        batch_len = msbl_pkg::SIZE + 1;
      end else if (batch_no == 1) begin
        batch_len = msbl_pkg::SIZE;
      end else if ($urandom_range(9) == 0) begin
        batch_len = $urandom_range(msbl_pkg::SIZE, msbl_pkg::SIZE + 4);
      end else begin
        batch_len = $urandom_range(1, 10);
      end
      for (int n = 0; n < batch_len; n++) begin
        logic [msbl_pkg::KEY_BITS-1:0] key;
        logic [msbl_pkg::TAG_BITS-1:0] tag;
        logic                          last;
        key  = pick_key();
        tag  = tag_t'($urandom_range(TAG_MAX));
        last = (n + 1 == batch_len);
        // a stretch in the middle runs with no gaps at all
        idling_on = !(sent >= 120 && sent < 240);
        send_request(key, tag, last);
        predict_sorted(key, tag, last);
        pending_results = {pending_results, batch_out};
        sent++;
      end
      batch_no++;
    end
    start_i <= 1'b0;

    // let every expected result come out, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("merge_sort_by_length verification clean");
    end else begin
      $display("merge_sort_by_length verification failed");
    end
    $finish;
  end

endmodule
